// File: hw/rtl/mpsm_pkg.sv
// Shared types and constants of the magnet pulse speed monitor.
package mpsm_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int TIME_W     = 32;
   localparam int ADC_BITS   = 12;
   localparam int FRAC_BITS  = 16;
   localparam int SAMPLE_MAX = (1 << ADC_BITS) - 1;
   localparam int AVG_W      = ADC_BITS + FRAC_BITS;
   localparam int ALPHA_W    = 16;
   localparam int PROD_W     = AVG_W + ALPHA_W;
   localparam int THR_W      = 12;
   localparam int MIN_INT_W  = 20;
   localparam int PPR_W      = 8;
   localparam int RPS_W      = 25;
   localparam int NUM_W      = 36;
   localparam int DEN_W      = TIME_W + PPR_W;
   localparam int DIV_CNT_W  = $clog2(NUM_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [AVG_W-1:0] EMA_MAX  = AVG_W'(SAMPLE_MAX) << FRAC_BITS;
   localparam logic [RPS_W-1:0] RPS_MAX  = {RPS_W{1'b1}};
   localparam logic [NUM_W-1:0] RATE_NUM = 36'd65_536_000_000;
   localparam logic [PROD_W:0]  ROUND_HALF = (PROD_W + 1)'(1) << (ALPHA_W - 1);

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HYSTERESIS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_INT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PPR        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_FAST = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_SLOW = 3'd5;

   typedef struct packed {
      logic [THR_W-1:0]     threshold;
      logic [THR_W-1:0]     hysteresis;
      logic [MIN_INT_W-1:0] min_interval;
      logic [PPR_W-1:0]     ppr;
      logic [ALPHA_W-1:0]   alpha_fast;
      logic [ALPHA_W-1:0]   alpha_slow;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic seed_add;
      logic ema_fast;
      logic ema_slow;
      logic ema_end;
      logic schmitt;
      logic div_start;
      logic seed_apply;
      logic speed_apply;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic seed_done;
      logic seed_last;
      logic batch_last;
      logic fire;
      logic dt_zero;
      logic div_busy;
      logic div_done;
   } sts_type;

   typedef struct packed {
      logic [RPS_W-1:0] rps_q16;
      logic             pulse;
      logic             armed_flag;
      logic             seeded;
   } res_type;

endpackage

// File: hw/rtl/mpsm_chan_if.sv
// Request and response channel interfaces of the magnet pulse speed monitor.
interface mpsm_req_if;
   logic                          valid;
   logic                          ready;
   logic [mpsm_pkg::SAMPLE_W-1:0] sample;
   logic [mpsm_pkg::TIME_W-1:0]   now_us;

   modport source (output valid, output sample, output now_us, input ready);
   modport sink (input valid, input sample, input now_us, output ready);
endinterface

interface mpsm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mpsm_pkg::RPS_W-1:0] rps_q16;
   logic                       pulse;
   logic                       armed_flag;
   logic                       seeded;

   modport source (output valid, output rps_q16, output pulse, output armed_flag,
                   output seeded, input ready);
   modport sink (input valid, input rps_q16, input pulse, input armed_flag,
                 input seeded, output ready);
endinterface

// File: hw/rtl/mpsm_csr.sv
// Configuration registers of the magnet pulse speed monitor.
module mpsm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [mpsm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpsm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output mpsm_pkg::cfg_type               cfg
);
   import mpsm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_THRESHOLD:  cfg_in.threshold    = csr_wdata[THR_W-1:0];
            REG_HYSTERESIS: cfg_in.hysteresis   = csr_wdata[THR_W-1:0];
            REG_MIN_INT:    cfg_in.min_interval = csr_wdata[MIN_INT_W-1:0];
            REG_PPR:        cfg_in.ppr          = csr_wdata[PPR_W-1:0];
            REG_ALPHA_FAST: cfg_in.alpha_fast   = csr_wdata[ALPHA_W-1:0];
            REG_ALPHA_SLOW: cfg_in.alpha_slow   = csr_wdata[ALPHA_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= THR_W'(25);
         cfg_ff.hysteresis   <= THR_W'(16);
         cfg_ff.min_interval <= MIN_INT_W'(3000);
         cfg_ff.ppr          <= PPR_W'(1);
         cfg_ff.alpha_fast   <= ALPHA_W'(13107);
         cfg_ff.alpha_slow   <= ALPHA_W'(1311);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/mpsm_div.sv
// Restoring divider of the magnet pulse speed monitor, one quotient bit per cycle.
module mpsm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mpsm_pkg::NUM_W-1:0] num,
   input  logic [mpsm_pkg::DEN_W-1:0] den,
   output logic [mpsm_pkg::NUM_W-1:0] quo,
   output logic                       busy,
   output logic                       done
);
   import mpsm_pkg::*;

   logic [NUM_W-1:0]     num_ff, num_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       trial_sub;
   logic                 fits;

   always_comb begin
      trial     = {rem_ff, num_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = trial >= {1'b0, den_ff};
      num_in    = num_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign quo  = quo_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

// File: hw/rtl/mpsm_dp.sv
// Datapath of the magnet pulse speed monitor: seeding, EMAs, Schmitt check, speed.
module mpsm_dp #(
   parameter int SAMPLES_PER_CHECK = 8,
   parameter int SEED_COUNT        = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mpsm_pkg::cfg_type             cfg,
   input  mpsm_pkg::cmd_type             cmd,
   output mpsm_pkg::sts_type             sts,
   input  logic [mpsm_pkg::SAMPLE_W-1:0] sample,
   input  logic [mpsm_pkg::TIME_W-1:0]   now_us,
   output mpsm_pkg::res_type             res
);
   import mpsm_pkg::*;

   localparam int SEED_CNT_W  = (SEED_COUNT > 1) ? $clog2(SEED_COUNT) : 1;
   localparam int SEED_SUM_W  = $clog2(SEED_COUNT * SAMPLE_MAX + 1);
   localparam int BATCH_W     = (SAMPLES_PER_CHECK > 1) ? $clog2(SAMPLES_PER_CHECK) : 1;
   localparam int SEED_SHIFT  = SEED_SUM_W + $clog2(SEED_COUNT);
   localparam int SEED_PROD_W = 2 * SEED_SUM_W + 1;
   localparam logic [SEED_SUM_W:0] SEED_RECIP =
      (SEED_SUM_W + 1)'(((64'd1 << SEED_SHIFT) + 64'(SEED_COUNT - 1)) / 64'(SEED_COUNT));

   logic [SAMPLE_W-1:0]   x_ff, x_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [AVG_W-1:0]      fast_ff, fast_in;
   logic [AVG_W-1:0]      slow_ff, slow_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  neg_ff, neg_in;
   logic [TIME_W-1:0]     dt_ff, dt_in;
   logic                  armed_ff, armed_in;
   logic                  pulse_ff, pulse_in;
   logic [TIME_W-1:0]     last_ff, last_in;
   logic [RPS_W-1:0]      speed_ff, speed_in;
   logic [BATCH_W-1:0]    batch_ff, batch_in;
   logic [SEED_CNT_W-1:0] seed_cnt_ff, seed_cnt_in;
   logic [SEED_SUM_W-1:0] seed_sum_ff, seed_sum_in;
   logic                  seed_done_ff, seed_done_in;
   res_type               res_ff, res_in;

   logic [AVG_W-1:0]      avg_sel;
   logic [ALPHA_W-1:0]    alpha_sel;
   logic [AVG_W-1:0]      x_scaled;
   logic                  diff_neg;
   logic [AVG_W-1:0]      mag;
   logic [PROD_W:0]       round_sum;
   logic [AVG_W-1:0]      step;
   logic [AVG_W-1:0]      ema_target;
   logic [AVG_W:0]        ema_sum;
   logic [AVG_W-1:0]      ema_new;
   logic [SEED_SUM_W-1:0] seed_sum_next;
   logic [SEED_PROD_W-1:0] seed_prod;
   logic [ADC_BITS-1:0]   seed_mean;
   logic [PPR_W-1:0]      ppr_eff;
   logic [DEN_W-1:0]      den_rate;
   logic [NUM_W-1:0]      div_num;
   logic [DEN_W-1:0]      div_den;
   logic [NUM_W-1:0]      div_quo;
   logic                  div_busy;
   logic                  div_done;
   logic [RPS_W-1:0]      inst;
   logic [RPS_W:0]        blend;
   logic [AVG_W:0]        high_lvl;
   logic signed [THR_W:0]   thr_diff;
   logic signed [AVG_W+1:0] low_lvl;
   logic                  ge_high;
   logic                  le_low;
   logic                  spaced;
   logic                  fire;

   always_comb begin
      avg_sel   = cmd.ema_slow ? slow_ff : fast_ff;
      alpha_sel = cmd.ema_slow ? cfg.alpha_slow : cfg.alpha_fast;
      x_scaled  = {x_ff, {FRAC_BITS{1'b0}}};
      diff_neg  = x_scaled < avg_sel;
      mag       = diff_neg ? avg_sel - x_scaled : x_scaled - avg_sel;

      round_sum  = {1'b0, prod_ff} + ROUND_HALF;
      step       = round_sum[ALPHA_W +: AVG_W];
      ema_target = cmd.ema_end ? slow_ff : fast_ff;
      ema_sum    = {1'b0, ema_target} + {1'b0, step};
      if (neg_ff) begin
         ema_new = (step > ema_target) ? '0 : ema_target - step;
      end else begin
         ema_new = (ema_sum > {1'b0, EMA_MAX}) ? EMA_MAX : ema_sum[AVG_W-1:0];
      end

      seed_sum_next = seed_sum_ff + SEED_SUM_W'(x_ff);
      seed_prod     = SEED_PROD_W'(seed_sum_ff) * SEED_PROD_W'(SEED_RECIP);
      seed_mean     = seed_prod[SEED_SHIFT +: ADC_BITS];
      ppr_eff       = (cfg.ppr == '0) ? PPR_W'(1) : cfg.ppr;
      den_rate      = DEN_W'(dt_ff) * DEN_W'(ppr_eff);
      div_num       = RATE_NUM;
      div_den       = den_rate;

      inst  = (div_quo > NUM_W'(RPS_MAX)) ? RPS_MAX : div_quo[RPS_W-1:0];
      blend = {1'b0, speed_ff} + {1'b0, inst};

      high_lvl = {1'b0, slow_ff} + {1'b0, cfg.threshold, {FRAC_BITS{1'b0}}};
      thr_diff = $signed({1'b0, cfg.threshold}) - $signed({1'b0, cfg.hysteresis});
      low_lvl  = $signed({2'b00, slow_ff}) + $signed({thr_diff[THR_W], thr_diff,
                                                     {FRAC_BITS{1'b0}}});
      ge_high  = {1'b0, fast_ff} >= high_lvl;
      le_low   = $signed({2'b00, fast_ff}) <= low_lvl;
      spaced   = dt_ff >= TIME_W'(cfg.min_interval);
      fire     = armed_ff && ge_high && spaced;
   end

   always_comb begin
      x_in         = x_ff;
      now_in       = now_ff;
      fast_in      = fast_ff;
      slow_in      = slow_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      dt_in        = dt_ff;
      armed_in     = armed_ff;
      pulse_in     = pulse_ff;
      last_in      = last_ff;
      speed_in     = speed_ff;
      batch_in     = batch_ff;
      seed_cnt_in  = seed_cnt_ff;
      seed_sum_in  = seed_sum_ff;
      seed_done_in = seed_done_ff;
      res_in       = res_ff;

      if (cmd.accept) begin
         x_in     = sample;
         now_in   = now_us;
         pulse_in = 1'b0;
      end
      if (cmd.seed_add) begin
         seed_sum_in = seed_sum_next;
         seed_cnt_in = seed_cnt_ff + SEED_CNT_W'(1);
      end
      if (cmd.seed_apply) begin
         fast_in      = {seed_mean, {FRAC_BITS{1'b0}}};
         slow_in      = {seed_mean, {FRAC_BITS{1'b0}}};
         armed_in     = 1'b1;
         last_in      = now_ff;
         seed_done_in = 1'b1;
         batch_in     = '0;
      end
      if (cmd.ema_fast || cmd.ema_slow) begin
         prod_in = PROD_W'(mag) * PROD_W'(alpha_sel);
         neg_in  = diff_neg;
      end
      if (cmd.ema_fast) begin
         dt_in = now_ff - last_ff;
      end
      if (cmd.ema_slow) begin
         fast_in = ema_new;
      end
      if (cmd.ema_end) begin
         slow_in  = ema_new;
         batch_in = (batch_ff == BATCH_W'(SAMPLES_PER_CHECK - 1)) ? '0
                                                                    : batch_ff + BATCH_W'(1);
      end
      if (cmd.schmitt) begin
         if (fire) begin
            pulse_in = 1'b1;
            last_in  = now_ff;
            armed_in = le_low;
         end else begin
            armed_in = armed_ff || le_low;
         end
      end
      if (cmd.speed_apply) begin
         speed_in = (speed_ff == '0) ? inst : blend[RPS_W:1];
      end
      if (cmd.load_out) begin
         res_in.rps_q16    = speed_ff;
         res_in.pulse      = pulse_ff;
         res_in.armed_flag = armed_ff;
         res_in.seeded     = seed_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff      <= '0;
         slow_ff      <= '0;
         armed_ff     <= 1'b0;
         pulse_ff     <= 1'b0;
         last_ff      <= '0;
         speed_ff     <= '0;
         batch_ff     <= '0;
         seed_cnt_ff  <= '0;
         seed_sum_ff  <= '0;
         seed_done_ff <= 1'b0;
      end else begin
         fast_ff      <= fast_in;
         slow_ff      <= slow_in;
         armed_ff     <= armed_in;
         pulse_ff     <= pulse_in;
         last_ff      <= last_in;
         speed_ff     <= speed_in;
         batch_ff     <= batch_in;
         seed_cnt_ff  <= seed_cnt_in;
         seed_sum_ff  <= seed_sum_in;
         seed_done_ff <= seed_done_in;
      end
      x_ff    <= x_in;
      now_ff  <= now_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      dt_ff   <= dt_in;
      res_ff  <= res_in;
   end

   mpsm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .busy  (div_busy),
      .done  (div_done)
   );

   always_comb begin
      sts.seed_done  = seed_done_ff;
      sts.seed_last  = seed_cnt_ff == SEED_CNT_W'(SEED_COUNT - 1);
      sts.batch_last = batch_ff == BATCH_W'(SAMPLES_PER_CHECK - 1);
      sts.fire       = fire;
      sts.dt_zero    = dt_ff == '0;
      sts.div_busy   = div_busy;
      sts.div_done   = div_done;
   end

   assign res = res_ff;

   a_seed_sticky: assert property (@(posedge clock) disable iff (reset)
      seed_done_ff |=> seed_done_ff)
      else $error("seeding flag dropped after completion");

   a_ema_range: assert property (@(posedge clock) disable iff (reset)
      fast_ff <= EMA_MAX && slow_ff <= EMA_MAX)
      else $error("moving average out of range");

endmodule

// File: hw/rtl/mpsm_ctrl.sv
// Sequencing state machine of the magnet pulse speed monitor.
module mpsm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  mpsm_pkg::sts_type sts,
   output mpsm_pkg::cmd_type cmd
);
   import mpsm_pkg::*;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_SEED       = 4'd1;
   localparam logic [3:0] ST_SEED_APPLY = 4'd2;
   localparam logic [3:0] ST_EMA_FAST   = 4'd3;
   localparam logic [3:0] ST_EMA_SLOW   = 4'd4;
   localparam logic [3:0] ST_EMA_END    = 4'd5;
   localparam logic [3:0] ST_SCHMITT    = 4'd6;
   localparam logic [3:0] ST_RATE_DIV   = 4'd7;
   localparam logic [3:0] ST_FINISH     = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.seed_done ? ST_EMA_FAST : ST_SEED;
            end
         end
         ST_SEED: begin
            cmd.seed_add = 1'b1;
            if (sts.seed_last) begin
               state_in = ST_SEED_APPLY;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SEED_APPLY: begin
            cmd.seed_apply = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_EMA_FAST: begin
            cmd.ema_fast = 1'b1;
            state_in     = ST_EMA_SLOW;
         end
         ST_EMA_SLOW: begin
            cmd.ema_slow = 1'b1;
            state_in     = ST_EMA_END;
         end
         ST_EMA_END: begin
            cmd.ema_end = 1'b1;
            state_in    = sts.batch_last ? ST_SCHMITT : ST_FINISH;
         end
         ST_SCHMITT: begin
            cmd.schmitt = 1'b1;
            if (sts.fire && !sts.dt_zero) begin
               cmd.div_start = 1'b1;
               state_in      = ST_RATE_DIV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RATE_DIV: begin
            if (sts.div_done) begin
               cmd.speed_apply = 1'b1;
               state_in        = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = out_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_ready))
      else $error("result register loaded over a pending beat");

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !sts.div_busy)
      else $error("divider busy while taking a new beat");

endmodule

// File: hw/rtl/magnet_pulse_speed_monitor.sv
// Magnet pulse speed monitor top level.
//
// Takes one beat per ADC sample on req_if (sample, now_us) and returns exactly
// one beat per sample on rsp_if (rps_q16, pulse, armed_flag, seeded).
// Configuration registers are written through csr_wr_en/csr_index/csr_wdata
// only while no sample is in flight; the user must ensure this, unchecked.
// States a request beat passes before FINISH loads its result:
//   seeding sample, not last: SEED
//   last seed sample: SEED, SEED_APPLY (reciprocal multiply of the seed sum)
//   tracking sample without check: EMA_FAST, EMA_SLOW, EMA_END
//   Schmitt check, no divide: tracking states, SCHMITT
//   pulse with dt > 0: tracking states, SCHMITT, RATE_DIV (36-bit rate divide)
// One sample is in work at a time; the next request beat is taken in the cycle
// after the result is loaded. The one-bit-per-cycle divider sets the long
// case. The result register lets the next request beat be taken while a
// finished result still waits; a stalled rsp_if holds its beat and the block
// stops before loading the next one. Unlisted CSR indexes are dropped.
// Synchronous reset clears the averages, the seeding progress, speed and all
// handshakes, and restores the register defaults.
module magnet_pulse_speed_monitor #(
   parameter int SAMPLES_PER_CHECK = 8,
   parameter int SEED_COUNT        = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   mpsm_req_if.sink                        req_if,
   mpsm_rsp_if.source                      rsp_if,
   input  logic                            csr_wr_en,
   input  logic [mpsm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpsm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mpsm_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   res_type res;

   mpsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mpsm_dp #(
      .SAMPLES_PER_CHECK (SAMPLES_PER_CHECK),
      .SEED_COUNT        (SEED_COUNT)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .cmd    (cmd),
      .sts    (sts),
      .sample (req_if.sample),
      .now_us (req_if.now_us),
      .res    (res)
   );

   mpsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign rsp_if.rps_q16    = res.rps_q16;
   assign rsp_if.pulse      = res.pulse;
   assign rsp_if.armed_flag = res.armed_flag;
   assign rsp_if.seeded     = res.seeded;

endmodule

// File: bench/magnet_pulse_speed_monitor_tb.sv
// Self-checking bench for the magnet pulse speed monitor: predicts and checks every response beat.
module magnet_pulse_speed_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mpsm_pkg::*;

   localparam int SEED_N      = 32;
   localparam int CHECK_N     = 8;
   localparam int STALL_LIMIT = 4000;
   localparam int REPORT_MAX  = 10;
   localparam int PHASE_ITEMS = 150;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mpsm_req_if req_if ();
   mpsm_rsp_if rsp_if ();

   magnet_pulse_speed_monitor #(
      .SAMPLES_PER_CHECK(CHECK_N),
      .SEED_COUNT       (SEED_N)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   cfg_type          cfg_m;
   logic [AVG_W-1:0] fast_avg;
   logic [AVG_W-1:0] slow_avg;
   logic             armed_m;
   logic [TIME_W-1:0] last_pulse_us;
   logic [RPS_W-1:0] speed_m;
   int unsigned      batch_n;
   int unsigned      seed_n;
   logic [16:0]      seed_acc;
   logic             seeded_m;

   res_type          pending_results[$];
   int               mismatch_count = 0;
   int unsigned      stall_cycles = 0;
   int unsigned      send_idle_pct = 29;
   int unsigned      recv_idle_pct = 62;
   logic [TIME_W-1:0] clock_us;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [AVG_W-1:0] ema_next(logic [AVG_W-1:0] avg,
                                                 logic [ADC_BITS-1:0] x,
                                                 logic [ALPHA_W-1:0] alpha);
      longint          diff;
      longint          nxt;
      longint unsigned mag;
      longint unsigned stp;
      diff = longint'({x, FRAC_BITS'(0)}) - longint'(avg);
      mag  = (diff < 0) ? -diff : diff;
      stp  = (mag * alpha + 64'd32768) >> 16;
      nxt  = (diff < 0) ? longint'(avg) - longint'(stp) : longint'(avg) + longint'(stp);
      if (nxt < 0) nxt = 0;
      if (nxt > longint'(EMA_MAX)) nxt = longint'(EMA_MAX);
      return AVG_W'(nxt);
   endfunction

   function automatic res_type predict_beat(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] now);
      logic [ADC_BITS-1:0] x;
      res_type             r;
      longint              hi_lvl;
      longint              lo_lvl;
      logic                fired;
      logic [TIME_W-1:0]   dt;
      longint unsigned     ppr;
      longint unsigned     inst;
      x     = s[ADC_BITS-1:0];
      fired = 1'b0;
      if (!seeded_m) begin
         seed_acc = seed_acc + 17'(x);
         seed_n++;
         if (seed_n >= SEED_N) begin
            fast_avg      = {ADC_BITS'(seed_acc / SEED_N), FRAC_BITS'(0)};
            slow_avg      = fast_avg;
            armed_m       = 1'b1;
            last_pulse_us = now;
            seeded_m      = 1'b1;
            batch_n       = 0;
         end
      end else begin
         fast_avg = ema_next(fast_avg, x, cfg_m.alpha_fast);
         slow_avg = ema_next(slow_avg, x, cfg_m.alpha_slow);
         batch_n++;
         if (batch_n >= CHECK_N) begin
            hi_lvl  = longint'(slow_avg) + (longint'(cfg_m.threshold) << FRAC_BITS);
            lo_lvl  = longint'(slow_avg) + (longint'(cfg_m.threshold) -
                      longint'(cfg_m.hysteresis)) * (longint'(1) << FRAC_BITS);
            batch_n = 0;
            if (armed_m && longint'(fast_avg) >= hi_lvl &&
                TIME_W'(now - last_pulse_us) >= TIME_W'(cfg_m.min_interval)) begin
               dt = now - last_pulse_us;
               if (dt != 0) begin
                  ppr  = (cfg_m.ppr == 0) ? 1 : cfg_m.ppr;
                  inst = (64'd1000000 << 16) / (64'(dt) * ppr);
                  if (inst > RPS_MAX) inst = RPS_MAX;
                  if (speed_m == 0) speed_m = RPS_W'(inst);
                  else speed_m = RPS_W'((64'(speed_m) + inst) >> 1);
               end
               last_pulse_us = now;
               armed_m       = 1'b0;
               fired         = 1'b1;
            end
            if (!armed_m && longint'(fast_avg) <= lo_lvl) armed_m = 1'b1;
         end
      end
      r.rps_q16    = speed_m;
      r.pulse      = fired;
      r.armed_flag = armed_m;
      r.seeded     = seeded_m;
      return r;
   endfunction

   function automatic void check_field(string name, logic [RPS_W-1:0] want,
                                       logic [RPS_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   function automatic logic [CSR_DATA_W-1:0] with_junk(int unsigned value, int width);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      if (width >= CSR_DATA_W) junk = '0;
      else junk = junk << width;
      return CSR_DATA_W'(value) | junk;
   endfunction

   task automatic send_sample(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] now);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid  = 1'b1;
      req_if.sample = s;
      req_if.now_us = now;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_results.push_back(predict_beat(s, now));
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         REG_THRESHOLD:  cfg_m.threshold    = data[THR_W-1:0];
         REG_HYSTERESIS: cfg_m.hysteresis   = data[THR_W-1:0];
         REG_MIN_INT:    cfg_m.min_interval = data[MIN_INT_W-1:0];
         REG_PPR:        cfg_m.ppr          = data[PPR_W-1:0];
         REG_ALPHA_FAST: cfg_m.alpha_fast   = data[ALPHA_W-1:0];
         REG_ALPHA_SLOW: cfg_m.alpha_slow   = data[ALPHA_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic apply_settings(int unsigned thr, int unsigned hyst, int unsigned min_us,
                                 int unsigned ppr, int unsigned af, int unsigned as);
      drain();
      csr_write(REG_THRESHOLD,  with_junk(thr, THR_W));
      csr_write(REG_HYSTERESIS, with_junk(hyst, THR_W));
      csr_write(REG_MIN_INT,    with_junk(min_us, MIN_INT_W));
      csr_write(REG_PPR,        with_junk(ppr, PPR_W));
      csr_write(REG_ALPHA_FAST, with_junk(af, ALPHA_W));
      csr_write(REG_ALPHA_SLOW, with_junk(as, ALPHA_W));
   endtask

   task automatic test_seeding();
      logic [SAMPLE_W-1:0] s;
      for (int i = 0; i < SEED_N; i++) begin
         case (i % 4)
            0: s = '0;
            1: s = '1;
            2: s = SAMPLE_W'($urandom);
            default: s = 12'h800;
         endcase
         clock_us = 32'hFFFF_FC00 + i * 16;
         send_sample(s, clock_us);
      end
   endtask

   task automatic test_zero_interval();
      logic [SAMPLE_W-1:0] lvl;
      apply_settings(0, 0, 0, 1, 13107, 1311);
      lvl = fast_avg[AVG_W-1:FRAC_BITS];
      // cross the time wrap, then repeat the same stamp, then step by one
      for (int i = 0; i < CHECK_N; i++) send_sample(lvl, 32'h0000_0040);
      for (int i = 0; i < CHECK_N; i++) send_sample(lvl, 32'h0000_0040);
      for (int i = 0; i < CHECK_N; i++) send_sample(lvl, 32'h0000_0041);
      clock_us = 32'h0000_0041;
   endtask

   task automatic test_sample_extremes();
      apply_settings(25, 16, 0, 1, 65535, 1311);
      for (int i = 0; i < 2 * CHECK_N; i++) begin
         clock_us = clock_us + 500;
         send_sample((i < CHECK_N) ? '1 : '0, clock_us);
      end
   endtask

   task automatic test_ppr_zero();
      apply_settings(0, 0, 0, 0, 65535, 1311);
      for (int i = 0; i < 2 * CHECK_N; i++) begin
         clock_us = clock_us + 700;
         send_sample('1, clock_us);
      end
   endtask

   task automatic test_unmapped_index();
      drain();
      csr_write(REG_UNMAPPED_LO, '1);
      csr_write(REG_UNMAPPED_HI, '1);
      for (int i = 0; i < CHECK_N; i++) begin
         clock_us = clock_us + 900;
         send_sample(SAMPLE_W'($urandom), clock_us);
      end
   endtask

   task automatic test_random_phase(int phase);
      int unsigned thr;
      int unsigned min_us;
      int unsigned max_step;
      int unsigned lo;
      int unsigned hi;
      int unsigned lvl;
      int unsigned run_left;
      int unsigned r;
      logic        high_side;
      logic [SAMPLE_W-1:0] s;
      case (phase)
         0: apply_settings(25, 16, 3000, 1, 13107, 1311);
         1: apply_settings(0, 0, 0, 255, 65535, 1);
         2: apply_settings(4095, 0, 1000000, 255, 1, 65535);
         3: apply_settings(12, 4095, 1000000, 1, 65535, 0);
         default: begin
            thr = $urandom_range(4, 80);
            apply_settings(thr, $urandom_range(0, thr + 20), $urandom_range(0, 8000),
                           $urandom_range(0, 12), $urandom_range(6000, 50000),
                           $urandom_range(100, 5000));
         end
      endcase
      min_us    = cfg_m.min_interval;
      max_step  = min_us / 10 + 100;
      lo        = $urandom_range(0, 3000);
      hi        = lo + $urandom_range(30, 1095);
      high_side = 1'b0;
      run_left  = $urandom_range(8, 48);
      if ($urandom_range(0, 3) == 0) clock_us = 32'hFFFF_FFFF - $urandom_range(0, 200 * max_step);
      else clock_us = $urandom;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (run_left == 0) begin
            high_side = !high_side;
            run_left  = $urandom_range(8, 48);
            if ($urandom_range(0, 9) == 0) begin
               lo = $urandom_range(0, 3000);
               hi = lo + $urandom_range(30, 1095);
            end
         end
         run_left--;
         r   = $urandom_range(0, 99);
         lvl = (high_side ? hi : lo) + $urandom_range(0, 6);
         if (r < 8) s = SAMPLE_W'($urandom);
         else s = (lvl > SAMPLE_MAX) ? '1 : SAMPLE_W'(lvl);
         if (r >= 97) clock_us = $urandom;
         else clock_us = clock_us + $urandom_range(0, max_step);
         send_sample(s, clock_us);
      end
   endtask

   always @(negedge clock) begin
      rsp_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : rsp_check
      res_type want;
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("response beat with no sample pending: rps_q16 %0d", rsp_if.rps_q16);
         end else begin
            want = pending_results.pop_front();
            check_field("rps_q16", want.rps_q16, rsp_if.rps_q16);
            check_field("pulse", RPS_W'(want.pulse), RPS_W'(rsp_if.pulse));
            check_field("armed_flag", RPS_W'(want.armed_flag), RPS_W'(rsp_if.armed_flag));
            check_field("seeded", RPS_W'(want.seeded), RPS_W'(rsp_if.seeded));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      req_if.now_us = '0;
      rsp_if.ready  = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      clock_us      = '0;

      cfg_m.threshold    = 25;
      cfg_m.hysteresis   = 16;
      cfg_m.min_interval = 3000;
      cfg_m.ppr          = 1;
      cfg_m.alpha_fast   = 13107;
      cfg_m.alpha_slow   = 1311;
      fast_avg      = '0;
      slow_avg      = '0;
      armed_m       = 1'b0;
      last_pulse_us = '0;
      speed_m       = '0;
      batch_n       = 0;
      seed_n        = 0;
      seed_acc      = '0;
      seeded_m      = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_seeding();
      test_zero_interval();
      test_sample_extremes();
      test_ppr_zero();
      test_unmapped_index();
      for (int p = 0; p < 8; p++) begin
         if (p == 3) begin
            send_idle_pct = 62;
            recv_idle_pct = 29;
         end
         if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         test_random_phase(p);
      end

      drain();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/mpsm_pkg.sv
hw/rtl/mpsm_chan_if.sv
hw/rtl/mpsm_csr.sv
hw/rtl/mpsm_div.sv
hw/rtl/mpsm_dp.sv
hw/rtl/mpsm_ctrl.sv
hw/rtl/magnet_pulse_speed_monitor.sv
bench/magnet_pulse_speed_monitor_tb.sv
